@@ hw/rtl/dqsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dqsc_pkg
// Shared types and constants for the dual quadrature step counter.
// ----------------------------------------------------------------------------
package dqsc_pkg;

  typedef struct packed {
    logic [7:0] buttons;
    logic [1:0] enc_a;
    logic [1:0] enc_b;
  } in_t;

  typedef struct packed {
    logic [15:0] count;
    logic        hex_mode;
    logic [1:0]  step_leds;
  } out_t;

  // button port, active low
  localparam logic [7:0] IDLE_PATTERN = 8'hFF;
  // pressed patterns (inverted sample)
  localparam logic [7:0] PAT_DOUBLE   = 8'h01;
  localparam logic [7:0] PAT_QUAD     = 8'h02;
  localparam logic [7:0] PAT_HEX      = 8'h04;

  // encoder phase codes
  localparam logic [1:0] ENC_FROM_UP  = 2'd1;
  localparam logic [1:0] ENC_FROM_DN  = 2'd2;
  localparam logic [1:0] ENC_DETENT   = 2'd3;

endpackage

@@ hw/rtl/dqsc_core.sv @@
// ----------------------------------------------------------------------------
// dqsc_core
// Mode flags, button press detection, encoder tracking and position count.
// ----------------------------------------------------------------------------
module dqsc_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  dqsc_pkg::in_t item,
  output dqsc_pkg::out_t res
);

  logic        double_flag, double_flag_next;
  logic        quad_flag, quad_flag_next;
  logic        hex_flag, hex_flag_next;
  logic        released, released_next;
  logic [7:0]  last_pressed, last_pressed_next;
  logic [1:0]  prev_a;
  logic [1:0]  prev_b;
  logic [15:0] position, position_next;

  logic [7:0]  pressed;
  logic        new_press;
  logic [15:0] step;
  logic [15:0] delta_a, delta_b;

  assign pressed   = ~item.buttons;
  assign new_press = (item.buttons != dqsc_pkg::IDLE_PATTERN) &&
                     (released || (item.buttons != last_pressed));

  always_comb begin
    double_flag_next  = double_flag;
    quad_flag_next    = quad_flag;
    hex_flag_next     = hex_flag;
    released_next     = released;
    last_pressed_next = last_pressed;
    if (item.buttons == dqsc_pkg::IDLE_PATTERN) begin
      released_next = 1'b1;
    end else begin
      released_next     = 1'b0;
      last_pressed_next = item.buttons;
    end
    if (new_press) begin
      if (pressed == dqsc_pkg::PAT_DOUBLE) begin
        double_flag_next = ~double_flag;
      end else if (pressed == dqsc_pkg::PAT_QUAD) begin
        quad_flag_next = ~quad_flag;
      end else if (pressed == dqsc_pkg::PAT_HEX) begin
        hex_flag_next = ~hex_flag;
      end
    end
  end

  // step uses this tick's flags
  always_comb begin
    case ({quad_flag_next, double_flag_next})
      2'b00:   step = 16'd1;
      2'b01:   step = 16'd2;
      2'b10:   step = 16'd4;
      default: step = 16'd0;
    endcase
  end

  always_comb begin
    delta_a = 16'd0;
    delta_b = 16'd0;
    if (item.enc_a == dqsc_pkg::ENC_DETENT) begin
      if (prev_a == dqsc_pkg::ENC_FROM_UP) begin
        delta_a = step;
      end else if (prev_a == dqsc_pkg::ENC_FROM_DN) begin
        delta_a = 16'd0 - step;
      end
    end
    if (item.enc_b == dqsc_pkg::ENC_DETENT) begin
      if (prev_b == dqsc_pkg::ENC_FROM_UP) begin
        delta_b = step;
      end else if (prev_b == dqsc_pkg::ENC_FROM_DN) begin
        delta_b = 16'd0 - step;
      end
    end
    position_next = position + delta_a + delta_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      double_flag  <= 1'b0;
      quad_flag    <= 1'b0;
      hex_flag     <= 1'b0;
      released     <= 1'b1;
      last_pressed <= 8'h00;
      prev_a       <= 2'd0;
      prev_b       <= 2'd0;
      position     <= 16'd0;
    end else if (fire) begin
      double_flag  <= double_flag_next;
      quad_flag    <= quad_flag_next;
      hex_flag     <= hex_flag_next;
      released     <= released_next;
      last_pressed <= last_pressed_next;
      prev_a       <= item.enc_a;
      prev_b       <= item.enc_b;
      position     <= position_next;
    end
  end

  assign res.count     = position_next;
  assign res.hex_mode  = hex_flag_next;
  assign res.step_leds = {quad_flag_next, double_flag_next};

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(position) && $stable(prev_a) && $stable(prev_b))
    else $error("state changed without a transfer");

  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    fire && double_flag_next && quad_flag_next |=> position == $past(position))
    else $error("position moved with both step flags set");

  a_flag_single_toggle: assert property (@(posedge clk) disable iff (rst)
    fire |-> $countones({double_flag_next ^ double_flag, quad_flag_next ^ quad_flag,
                         hex_flag_next ^ hex_flag}) <= 1)
    else $error("more than one mode flag toggled");

endmodule

@@ hw/rtl/dual_quadrature_step_counter_unit.sv @@
// ----------------------------------------------------------------------------
// dual_quadrature_step_counter_unit
// Two-encoder position counter with button-selected step size and display mode.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; state updates as the item
//   leaves the input register; a stalled result also stalls the input.
// Throughput: one item per cycle while the result is not stalled.
// Reset: flags clear, released set, position and encoder history zero,
//   both pipeline stages empty.
module dual_quadrature_step_counter_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  dqsc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output dqsc_pkg::out_t out_data
);

  logic           s1_valid;
  dqsc_pkg::in_t  s1_data;
  logic           advance;
  logic           fire;
  dqsc_pkg::out_t res;

  assign advance  = !(out_valid && out_stall);
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  dqsc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_data),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with nothing held");

  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed item did not reach the result register");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
